FILE: rtl/core/tbpg_pkg.sv
// Shared types, constants and the fixed palette of the tile background
// pixel generator. No dependencies.
package tbpg_pkg;

	localparam int unsigned VRAM_BYTES_DEF = 16384;
	localparam int unsigned VADDR_W        = 14;
	localparam int unsigned CFG_IDX_W      = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_BASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLR_BASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATT_BASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_BD   = 3'd5;

	// display mode codes, {M5 M4 M3 M2 M1}
	localparam logic [4:0] MODE_G1 = 5'd0;
	localparam logic [4:0] MODE_T1 = 5'd1;
	localparam logic [4:0] MODE_MC = 5'd2;
	localparam logic [4:0] MODE_G2 = 5'd4;

	localparam logic [7:0] GREY_LEVEL = 8'h60;

	typedef struct packed {
		logic [7:0] mode_low;
		logic [7:0] mode_high;
		logic [7:0] name_base;
		logic [7:0] colr_base;
		logic [7:0] patt_base;
		logic [7:0] text_bd;
	} cfg_t;

	// hand-over from the sequencer to the colour resolve stage
	typedef struct packed {
		logic       valid;
		logic       supported;
		logic       text;
		logic       force_bd;
		logic [2:0] bit_pos;
		logic [7:0] bits;
	} fin_t;

	function automatic logic [4:0] mode_code(input cfg_t cfg);
		mode_code = {cfg.mode_low[3:1], cfg.mode_high[3], cfg.mode_high[4]};
	endfunction

	function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
		case (idx)
			4'd0:    palette_rgb = 24'h000000;
			4'd1:    palette_rgb = 24'h000000;
			4'd2:    palette_rgb = 24'h21C842;
			4'd3:    palette_rgb = 24'h5EDC78;
			4'd4:    palette_rgb = 24'h5455ED;
			4'd5:    palette_rgb = 24'h7D76FC;
			4'd6:    palette_rgb = 24'hD4524D;
			4'd7:    palette_rgb = 24'h42EBF5;
			4'd8:    palette_rgb = 24'hFC5554;
			4'd9:    palette_rgb = 24'hFF7978;
			4'd10:   palette_rgb = 24'hD4C154;
			4'd11:   palette_rgb = 24'hE6CE80;
			4'd12:   palette_rgb = 24'h21B03B;
			4'd13:   palette_rgb = 24'hC95BBA;
			4'd14:   palette_rgb = 24'hCCCCCC;
			default: palette_rgb = 24'hFFFFFF;
		endcase
	endfunction

endpackage

FILE: rtl/core/tile_background_pixel_generator_top.sv
// Top level of the tile background pixel generator: configuration registers
// and the wiring of sequencer, video memory and colour resolve.
// Depends on tbpg_pkg, tbpg_vram, tbpg_seq, tbpg_resolve.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_ready   | mode, vram_addr, vram_data, pixel_x, pixel_y
//  out     | out_valid / out_ready | mode_supported, color_index, red, green, blue
//  cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
// A pixel item reads the name, pattern and colour bytes one after another
// through the single read port of the video memory. The next item is taken
// while the colour read is in flight. Write items go to memory on acceptance
// and can follow each other every cycle while no pixel read is under way and
// the sequencer does not hold.
// Reset clears the configuration registers and all control state; the video
// memory is not cleared (reading a byte never written gives an undefined
// pixel). While a finished pixel waits for a full output register the
// sequencer and in_ready hold.
module tile_background_pixel_generator_top #(
	parameter int unsigned VRAM_BYTES = tbpg_pkg::VRAM_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [tbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                      cfg_data,
	// input items
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [tbpg_pkg::VADDR_W-1:0]    vram_addr,
	input  logic [7:0]                      vram_data,
	input  logic [7:0]                      pixel_x,
	input  logic [7:0]                      pixel_y,
	// result items
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            mode_supported,
	output logic [3:0]                      color_index,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue
);
	import tbpg_pkg::*;

	cfg_t                 cfg_q;
	fin_t                 fin;
	logic                 fin_ready;
	logic                 wr_en, rd_en;
	logic [VADDR_W-1:0]   rd_addr;
	logic [7:0]           rd_data;

	// register file; the user writes it only while the block is idle, unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE_LOW:  cfg_q.mode_low  <= cfg_data;
				REG_MODE_HIGH: cfg_q.mode_high <= cfg_data;
				REG_NAME_BASE: cfg_q.name_base <= cfg_data;
				REG_COLR_BASE: cfg_q.colr_base <= cfg_data;
				REG_PATT_BASE: cfg_q.patt_base <= cfg_data;
				REG_TEXT_BD:   cfg_q.text_bd   <= cfg_data;
				default: ;
			endcase
		end
	end

	tbpg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.wr_en     (wr_en),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.fin       (fin),
		.fin_ready (fin_ready)
	);

	// write items go straight to memory on acceptance
	tbpg_vram #(
		.VRAM_BYTES (VRAM_BYTES)
	) u_vram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (vram_addr),
		.wr_data (vram_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// colour byte arrives on rd_data in the cycle after the colour read
	tbpg_resolve u_resolve (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.fin            (fin),
		.fin_ready      (fin_ready),
		.colr_byte      (rd_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.mode_supported (mode_supported),
		.color_index    (color_index),
		.red            (red),
		.green          (green),
		.blue           (blue)
	);

endmodule

FILE: rtl/core/tbpg_vram.sv
// Video memory: one write port, one registered read port with enable.
// Depends on tbpg_pkg.
module tbpg_vram #(
	parameter int unsigned VRAM_BYTES = tbpg_pkg::VRAM_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [tbpg_pkg::VADDR_W-1:0]  wr_addr,
	input  logic [7:0]                    wr_data,
	input  logic                          rd_en,
	input  logic [tbpg_pkg::VADDR_W-1:0]  rd_addr,
	output logic [7:0]                    rd_data
);
	import tbpg_pkg::*;

	localparam int unsigned AW = $clog2(VRAM_BYTES);

	logic [7:0] mem [VRAM_BYTES];

	// read-first: a read and a write to one entry in the same cycle see old data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(wr_addr)] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[AW'(rd_addr)];
		end
	end

endmodule

FILE: rtl/core/tbpg_seq.sv
// Item slot, read sequencer and table address generation (name, pattern,
// colour). Depends on tbpg_pkg.
module tbpg_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tbpg_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [7:0]                    pixel_x,
	input  logic [7:0]                    pixel_y,
	output logic                          wr_en,
	output logic                          rd_en,
	output logic [tbpg_pkg::VADDR_W-1:0]  rd_addr,
	input  logic [7:0]                    rd_data,
	output tbpg_pkg::fin_t                fin,
	input  logic                          fin_ready
);
	import tbpg_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_NAME = 2'd1;
	localparam logic [1:0] PH_PAT  = 2'd2;
	localparam logic [1:0] PH_COL  = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [7:0] px_q, py_q, name_q;
	fin_t       fin_s1;

	logic       stall, accept, pix_acc, col_adv;
	logic [4:0] code;
	logic       is_text, is_g2;
	logic [4:0] row;
	logic [2:0] line;
	logic [7:0] tv, t6;
	logic [15:0] tprod;
	logic [5:0] tcol;
	logic [7:0] tsub;
	logic [9:0] toff;
	logic [9:0] g2_pat, g2_col;
	logic [2:0] xi;

	assign stall    = fin_s1.valid && !fin_ready;
	assign in_ready = !stall && (phase_q == PH_IDLE || phase_q == PH_COL);
	assign accept   = in_valid && in_ready;
	assign pix_acc  = accept && mode;
	assign wr_en    = accept && !mode;
	assign col_adv  = !stall && phase_q == PH_COL;
	assign fin      = fin_s1;

	assign code    = mode_code(cfg);
	assign is_text = code == MODE_T1;
	assign is_g2   = code == MODE_G2;
	assign row     = py_q[7:3];
	assign line    = py_q[2:0];

	// text cells are 6 pixels: divide by 6 as multiply by 171/1024
	assign tv    = px_q - 8'd8;
	assign tprod = 16'(tv) * 16'd171;
	assign tcol  = tprod[15:10];
	assign t6    = 8'({tcol, 2'b00}) + 8'({tcol, 1'b0});
	assign tsub  = tv - t6;
	assign toff  = 10'({row, 5'b0}) + 10'({row, 3'b0}) + 10'(tcol);
	assign xi    = is_text ? tsub[2:0] : px_q[2:0];

	assign g2_pat = {py_q[7:6], rd_data} & {cfg.patt_base[1:0], 8'hFF};
	assign g2_col = {py_q[7:6], name_q} & {cfg.colr_base[6:0], 3'b111};

	always_comb begin
		rd_en   = !stall && phase_q != PH_IDLE;
		rd_addr = '0;
		case (phase_q)
			PH_NAME: begin
				rd_addr = is_text ? {cfg.name_base[3:0], toff}
				                  : {cfg.name_base[3:0], row, px_q[7:3]};
			end
			PH_PAT: begin
				rd_addr = is_g2 ? {cfg.patt_base[2], g2_pat, line}
				                : {cfg.patt_base[2:0], rd_data, line};
			end
			PH_COL: begin
				rd_addr = is_g2 ? {cfg.colr_base[7], g2_col, line}
				                : {cfg.colr_base, 1'b0, name_q[7:3]};
			end
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		if (!stall) begin
			case (phase_q)
				PH_IDLE: phase_d = pix_acc ? PH_NAME : PH_IDLE;
				PH_NAME: phase_d = PH_PAT;
				PH_PAT:  phase_d = PH_COL;
				PH_COL:  phase_d = pix_acc ? PH_NAME : PH_IDLE;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fin_s1  <= '0;
		end else begin
			phase_q      <= phase_d;
			fin_s1.valid <= col_adv || (fin_s1.valid && !fin_ready);
			if (col_adv) begin
				fin_s1.supported <= code inside {MODE_G1, MODE_T1, MODE_MC, MODE_G2};
				fin_s1.text      <= is_text;
				fin_s1.force_bd  <= py_q >= 8'd192 ||
				                    (is_text && (px_q < 8'd8 || px_q >= 8'd248));
				fin_s1.bit_pos   <= 3'd7 - xi;
				fin_s1.bits      <= rd_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (!stall && phase_q == PH_PAT) begin
			name_q <= rd_data;
		end
	end

endmodule

FILE: rtl/core/tbpg_resolve.sv
// Colour resolve and output register: picks the palette index from pattern
// and colour bytes, backdrop rules, and looks up RGB. Depends on tbpg_pkg.
module tbpg_resolve (
	input  logic            clk,
	input  logic            arst_n,
	input  tbpg_pkg::cfg_t  cfg,
	input  tbpg_pkg::fin_t  fin,
	output logic            fin_ready,
	input  logic [7:0]      colr_byte,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            mode_supported,
	output logic [3:0]      color_index,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);
	import tbpg_pkg::*;

	logic        out_valid_q;
	logic        sup_q;
	logic [3:0]  idx_q;
	logic [23:0] rgb_q;

	logic        pbit;
	logic [3:0]  backdrop, ci, idx;
	logic [23:0] rgb;
	logic        load;

	assign fin_ready = !out_valid_q || out_ready;
	assign load      = fin.valid && fin_ready;
	assign backdrop  = cfg.text_bd[3:0];
	assign pbit      = fin.bits[fin.bit_pos];

	always_comb begin
		ci = pbit ? colr_byte[7:4] : colr_byte[3:0];
		if (!fin.supported) begin
			idx = 4'd0;
		end else if (fin.force_bd) begin
			idx = backdrop;
		end else if (fin.text) begin
			idx = pbit ? cfg.text_bd[7:4] : backdrop;
		end else begin
			idx = (ci == 4'd0) ? backdrop : ci;
		end
		rgb = fin.supported ? palette_rgb(idx) : {3{GREY_LEVEL}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_ready) begin
			out_valid_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sup_q <= fin.supported;
			idx_q <= idx;
			rgb_q <= rgb;
		end
	end

	assign out_valid      = out_valid_q;
	assign mode_supported = sup_q;
	assign color_index    = idx_q;
	assign red            = rgb_q[23:16];
	assign green          = rgb_q[15:8];
	assign blue           = rgb_q[7:0];

endmodule

FILE: sim/tb_tile_background_pixel_generator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for tile_background_pixel_generator_top: writes each
// video memory byte before a pixel reads it, runs a directed table and then random
// phases against a predictor. Depends on tbpg_pkg and the block's RTL.
module tb_tile_background_pixel_generator_top;
	import tbpg_pkg::*;

	localparam int unsigned VRAM_DEPTH   = VRAM_BYTES_DEF;
	localparam int unsigned ITEM_BUDGET  = 2000;   // input items in the whole run
	localparam int unsigned IDLE_TAIL    = 8;      // settle time after the last pending result
	localparam int unsigned HOLD_CYCLES  = 300;    // long receiver hold-off
	localparam int unsigned TIMEOUT_NS   = 15_000_000;

	localparam logic ITEM_WRITE = 1'b0;
	localparam logic ITEM_PIXEL = 1'b1;

	// fixed 16-colour table, index 15 in the top bits
	localparam logic [16*24-1:0] PAL_TABLE = {
		24'hFFFFFF, 24'hCCCCCC, 24'hC95BBA, 24'h21B03B,
		24'hE6CE80, 24'hD4C154, 24'hFF7978, 24'hFC5554,
		24'h42EBF5, 24'hD4524D, 24'h7D76FC, 24'h5455ED,
		24'h5EDC78, 24'h21C842, 24'h000000, 24'h000000
	};

	typedef struct packed {
		logic                op;
		logic [VADDR_W-1:0]  addr;
		logic [7:0]          data;
		logic [7:0]          x;
		logic [7:0]          y;
	} vid_item_t;

	typedef struct packed {
		logic       supported;
		logic [3:0] pal_idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_res_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

	typedef struct packed {
		row_kind_e              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [7:0]             reg_val;
		vid_item_t              item;
		bit                     typed;
		pix_res_t               want;
	} stim_row_t;

	// results that can be read straight off the rules
	localparam pix_res_t RES_UNSUP   = {1'b0, 4'd0, GREY_LEVEL, GREY_LEVEL, GREY_LEVEL};
	localparam pix_res_t RES_BD_BLUE = {1'b1, 4'd4, 24'h5455ED};
	localparam pix_res_t RES_BLACK   = {1'b1, 4'd0, 24'h000000};
	localparam pix_res_t RES_BD_GREY = {1'b1, 4'd14, 24'hCCCCCC};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [7:0]            cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  mode      = 1'b0;
	logic [VADDR_W-1:0]    vram_addr = '0;
	logic [7:0]            vram_data = '0;
	logic [7:0]            pixel_x   = '0;
	logic [7:0]            pixel_y   = '0;
	logic                  out_ready = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  mode_supported;
	logic [3:0]            color_index;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;

	// shadow copy of video memory and registers, as the block should hold them
	logic [7:0]  vram_img [VRAM_DEPTH];
	bit          vram_wr  [VRAM_DEPTH];   // shadow entries that hold a written byte
	logic [7:0]  cur_mode_low  = '0;
	logic [7:0]  cur_mode_high = '0;
	logic [7:0]  cur_name_base = '0;
	logic [7:0]  cur_colr_base = '0;
	logic [7:0]  cur_patt_base = '0;
	logic [7:0]  cur_text_bd   = '0;

	pix_res_t    pending_pixels [$];   // pixels accepted, result not yet seen
	stim_row_t   stim_rows [$];
	int unsigned err_count  = 0;
	int unsigned burst_left = 0;
	int unsigned sent_count = 0;       // input items accepted so far
	int          miss_addr  = -1;      // first unwritten byte seen by a prediction
	bit          hold_req   = 1'b0;

	tile_background_pixel_generator_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.vram_addr      (vram_addr),
		.vram_data      (vram_data),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.mode_supported (mode_supported),
		.color_index    (color_index),
		.red            (red),
		.green          (green),
		.blue           (blue)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit, well above the slowest legal run
	initial begin
		#(TIMEOUT_NS);
		$display("tb_tile_background_pixel_generator_top: FAIL");
		$finish;
	end

	function automatic int unsigned vram_rd(input int unsigned a);
		int unsigned ea;
		ea = a % VRAM_DEPTH;
		if (!vram_wr[ea] && miss_addr < 0)
			miss_addr = int'(ea);
		return vram_img[ea];
	endfunction

	// background pixel at (px, py) from the shadow memory and registers
	function automatic pix_res_t predict_pixel(input logic [7:0] px, input logic [7:0] py);
		logic [4:0]  code;
		logic [3:0]  bd;
		logic [3:0]  idx;
		int unsigned nt, pg, ct, row, line, col, xi, name, bits, colr;
		int unsigned entry, pmask, cmask, pat_a, col_a;
		pix_res_t    res;
		code = {cur_mode_low[3:1], cur_mode_high[3], cur_mode_high[4]};
		if (code != MODE_G1 && code != MODE_T1 && code != MODE_MC && code != MODE_G2)
			return RES_UNSUP;
		bd   = cur_text_bd[3:0];
		nt   = int'(cur_name_base[3:0]) << 10;
		row  = py >> 3;
		line = py & 7;
		if (py >= 192) begin
			idx = bd;
		end else if (code == MODE_T1) begin
			// 40 cells of 6 pixels, 8-pixel margins at both sides
			pg = (int'(cur_patt_base) & 7) << 11;
			if (px < 8 || px >= 248) begin
				idx = bd;
			end else begin
				col  = (px - 8) / 6;
				xi   = (px - 8) % 6;
				name = vram_rd(nt + row * 40 + col);
				bits = vram_rd(pg + name * 8 + line);
				idx  = ((bits >> (7 - xi)) & 1) != 0 ? cur_text_bd[7:4] : bd;
			end
		end else begin
			col  = px >> 3;
			xi   = px & 7;
			name = vram_rd(nt + row * 32 + col);
			if (code == MODE_G2) begin
				// screen thirds, pattern and colour tables masked
				pg    = (int'(cur_patt_base) & 4) << 11;
				ct    = (int'(cur_colr_base) & 8'h80) << 6;
				pmask = ((int'(cur_patt_base) & 3) << 8) | 8'hFF;
				cmask = ((int'(cur_colr_base) & 8'h7F) << 3) | 7;
				entry = (row / 8) * 256 + name;
				pat_a = pg + (entry & pmask) * 8 + line;
				col_a = ct + (entry & cmask) * 8 + line;
			end else begin
				// graphic 1 and multicolor: one colour byte per 8 names
				pg    = (int'(cur_patt_base) & 7) << 11;
				ct    = int'(cur_colr_base) << 6;
				pat_a = pg + name * 8 + line;
				col_a = ct + name / 8;
			end
			bits = vram_rd(pat_a);
			colr = vram_rd(col_a);
			idx  = ((bits >> (7 - xi)) & 1) != 0 ? 4'((colr >> 4) & 15) : 4'(colr & 15);
			if (idx == 4'd0)
				idx = bd;
		end
		res.supported = 1'b1;
		res.pal_idx   = idx;
		{res.red, res.green, res.blue} = PAL_TABLE[idx * 24 +: 24];
		return res;
	endfunction

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		stim_row_t r;
		r         = '0;
		r.kind    = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		stim_rows.push_back(r);
	endtask

	task automatic add_item(input logic op, input logic [VADDR_W-1:0] a, input logic [7:0] d,
			input logic [7:0] x, input logic [7:0] y);
		stim_row_t r;
		r      = '0;
		r.kind = ROW_ITEM;
		r.item = {op, a, d, x, y};
		stim_rows.push_back(r);
	endtask

	task automatic add_pix_want(input logic [7:0] x, input logic [7:0] y, input pix_res_t want);
		stim_row_t r;
		r       = '0;
		r.kind  = ROW_ITEM;
		r.item  = {ITEM_PIXEL, {VADDR_W{1'b0}}, 8'h00, x, y};
		r.typed = 1'b1;
		r.want  = want;
		stim_rows.push_back(r);
	endtask

	// Offers one item in bursts with random gaps. Called and returns at a falling
	// edge; valid is left high so a following item keeps it up without a glitch.
	task automatic send_item(input vid_item_t it, input bit typed, input pix_res_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		mode      <= it.op;
		vram_addr <= it.addr;
		vram_data <= it.data;
		pixel_x   <= it.x;
		pixel_y   <= it.y;
		do @(posedge clk); while (in_ready !== 1'b1);
		sent_count++;
		if (it.op == ITEM_WRITE) begin
			vram_img[it.addr % VRAM_DEPTH] = it.data;
			vram_wr[it.addr % VRAM_DEPTH]  = 1'b1;
		end else begin
			pending_pixels.push_back(typed ? want : predict_pixel(it.x, it.y));
		end
		@(negedge clk);
	endtask

	// Writes, one item at a time, every byte that the pixel at (x, y) would read
	// and that has never been written, so a pixel only ever sees written bytes.
	task automatic fill_reads(input logic [7:0] x, input logic [7:0] y);
		vid_item_t wr;
		forever begin
			miss_addr = -1;
			void'(predict_pixel(x, y));
			if (miss_addr < 0)
				break;
			wr      = '0;
			wr.op   = ITEM_WRITE;
			wr.addr = VADDR_W'(miss_addr);
			wr.data = 8'($urandom);
			send_item(wr, 1'b0, '0);
		end
	endtask

	task automatic send_pixel_safe(input vid_item_t it, input bit typed, input pix_res_t want);
		if (it.op == ITEM_PIXEL)
			fill_reads(it.x, it.y);
		send_item(it, typed, want);
	endtask

	// stop offering and let every pending pixel come out, plus in-flight writes
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (IDLE_TAIL) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_MODE_LOW:  cur_mode_low  = val;
			REG_MODE_HIGH: cur_mode_high = val;
			REG_NAME_BASE: cur_name_base = val;
			REG_COLR_BASE: cur_colr_base = val;
			REG_PATT_BASE: cur_patt_base = val;
			REG_TEXT_BD:   cur_text_bd   = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic report_field(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
			err_count++;
		end
	endtask

	// Receiver: cycles through always-ready, coin-flip, mostly-stalled and a
	// fixed pattern; on request it holds off for a long stretch on its own count.
	initial begin : rx_proc
		int unsigned hold_left;
		int unsigned rx_cyc;
		hold_left = 0;
		rx_cyc    = 0;
		forever begin
			@(negedge clk);
			rx_cyc++;
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				case ((rx_cyc / 97) % 4)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (rx_cyc % 5 != 0);
				endcase
			end
		end
	end

	// each accepted result against the oldest pending pixel
	always @(posedge clk) begin : res_check
		pix_res_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t ns: result with no pixel pending, expected none, got 0x%0h",
					$time, {mode_supported, color_index, red, green, blue});
				err_count++;
			end else begin
				want = pending_pixels.pop_front();
				report_field("mode_supported", want.supported, mode_supported);
				report_field("color_index", want.pal_idx, color_index);
				report_field("red", want.red, red);
				report_field("green", want.green, green);
				report_field("blue", want.blue, blue);
			end
		end
	end

	initial begin : main_seq
		vid_item_t   it;
		logic [7:0]  regv [6];
		logic [4:0]  code;
		int unsigned sel;
		int unsigned n_phase;
		int unsigned n_items;
		bit          cfg_open;

		// Directed table. After reset the block is in graphic 1.
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd0, 8'd0);
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd255, 8'd191);
		add_item(ITEM_WRITE, 14'h3FFF, 8'hFF, 8'd0, 8'd0);
		add_item(ITEM_WRITE, 14'h0000, 8'h00, 8'd0, 8'd0);   // name/pattern/colour byte 0
		// unsupported codes: M3..M5 all set, M3 with M2, everything set
		add_cfg(REG_MODE_LOW, 8'h0E);
		add_pix_want(8'd17, 8'd3, RES_UNSUP);
		add_cfg(REG_MODE_LOW, 8'h02);
		add_cfg(REG_MODE_HIGH, 8'h08);
		add_pix_want(8'd200, 8'd100, RES_UNSUP);
		add_cfg(REG_MODE_LOW, 8'hFF);
		add_cfg(REG_MODE_HIGH, 8'hFF);
		add_pix_want(8'd255, 8'd255, RES_UNSUP);
		// text 1: margins and rows past the screen show the backdrop
		add_cfg(REG_MODE_LOW, 8'h00);
		add_cfg(REG_MODE_HIGH, 8'h10);
		add_cfg(REG_TEXT_BD, 8'hF4);
		add_pix_want(8'd0, 8'd0, RES_BD_BLUE);
		add_pix_want(8'd7, 8'd100, RES_BD_BLUE);
		add_pix_want(8'd248, 8'd0, RES_BD_BLUE);
		add_pix_want(8'd255, 8'd191, RES_BD_BLUE);
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd8, 8'd0);
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd247, 8'd191);
		add_pix_want(8'd100, 8'd192, RES_BD_BLUE);
		add_pix_want(8'd128, 8'd255, RES_BD_BLUE);
		// text colour 0 stays 0
		add_cfg(REG_TEXT_BD, 8'h00);
		add_pix_want(8'd100, 8'd50, RES_BLACK);
		// graphic 1: byte 0 is zero, so pixel (0,0) resolves to colour 0 -> backdrop
		add_cfg(REG_MODE_HIGH, 8'h00);
		add_cfg(REG_TEXT_BD, 8'h0E);
		add_pix_want(8'd0, 8'd0, RES_BD_GREY);
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd131, 8'd77);
		add_pix_want(8'd60, 8'd192, RES_BD_GREY);
		// multicolor
		add_cfg(REG_MODE_HIGH, 8'h08);
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd9, 8'd9);
		add_pix_want(8'd0, 8'd200, RES_BD_GREY);
		// graphic 2 with every base and mask bit up but the pattern table base bit
		add_cfg(REG_MODE_LOW, 8'h02);
		add_cfg(REG_MODE_HIGH, 8'h00);
		add_cfg(REG_NAME_BASE, 8'h0F);
		add_cfg(REG_COLR_BASE, 8'hFF);
		add_cfg(REG_PATT_BASE, 8'h03);
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd255, 8'd191);
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd0, 8'd0);
		add_item(ITEM_PIXEL, 14'd0, 8'h00, 8'd123, 8'd64);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the table; a run of register rows waits for the block to go idle first.
		cfg_open = 1'b0;
		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					drain_block();
					cfg_open = 1'b1;
				end
				cfg_write(stim_rows[i].reg_idx, stim_rows[i].reg_val);
			end else begin
				if (cfg_open) begin
					cfg_we   <= 1'b0;
					cfg_open = 1'b0;
				end
				send_pixel_safe(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
			end
		end

		// Random phases: a fresh register set each time, mostly a rendered mode.
		n_phase = 0;
		while (sent_count < ITEM_BUDGET) begin
			drain_block();
			for (int k = 0; k < 6; k++) begin
				case ($urandom_range(0, 9))
					0:       regv[k] = 8'h00;
					1:       regv[k] = 8'hFF;
					default: regv[k] = 8'($urandom);
				endcase
			end
			sel = $urandom_range(0, 9);
			if (sel < 8) begin
				case (sel / 2)
					0:       code = MODE_G1;
					1:       code = MODE_T1;
					2:       code = MODE_MC;
					default: code = MODE_G2;
				endcase
				regv[REG_MODE_LOW]  = (regv[REG_MODE_LOW] & 8'hF1) | {4'b0, code[4:2], 1'b0};
				regv[REG_MODE_HIGH] = (regv[REG_MODE_HIGH] & 8'hE7) |
					{3'b0, code[0], code[1], 3'b0};
			end
			cfg_write(REG_MODE_LOW, regv[REG_MODE_LOW]);
			cfg_write(REG_MODE_HIGH, regv[REG_MODE_HIGH]);
			cfg_write(REG_NAME_BASE, regv[REG_NAME_BASE]);
			cfg_write(REG_COLR_BASE, regv[REG_COLR_BASE]);
			cfg_write(REG_PATT_BASE, regv[REG_PATT_BASE]);
			cfg_write(REG_TEXT_BD, regv[REG_TEXT_BD]);
			cfg_we <= 1'b0;

			// the first phase runs into a long receiver hold-off, so the block backs up
			if (n_phase == 0)
				hold_req = 1'b1;
			n_items = $urandom_range(60, 180);
			for (int i = 0; i < n_items && sent_count < ITEM_BUDGET; i++) begin
				// once, the sender stops mid-phase until every pixel is out
				if (n_phase == 1 && i == n_items / 2)
					drain_block();
				it.op   = ($urandom_range(0, 3) == 0) ? ITEM_WRITE : ITEM_PIXEL;
				it.addr = VADDR_W'($urandom_range(0, VRAM_DEPTH - 1));
				it.data = 8'($urandom);
				sel = $urandom_range(0, 59);
				case (sel)
					0:       it.x = 8'd0;
					1:       it.x = 8'd7;
					2:       it.x = 8'd8;
					3:       it.x = 8'd247;
					4:       it.x = 8'd248;
					5:       it.x = 8'd255;
					default: it.x = 8'($urandom);
				endcase
				sel = $urandom_range(0, 19);
				if (sel == 0)
					it.y = 8'($urandom_range(192, 255));
				else if (sel == 1)
					it.y = 8'd0;
				else if (sel == 2)
					it.y = 8'd191;
				else
					it.y = 8'($urandom_range(0, 191));
				send_pixel_safe(it, 1'b0, '0);
			end
			n_phase++;
		end

		drain_block();
		if (err_count == 0 && pending_pixels.size() == 0)
			$display("tb_tile_background_pixel_generator_top: PASS");
		else
			$display("tb_tile_background_pixel_generator_top: FAIL");
		$finish;
	end

endmodule
